// ===== rtl/bcf_pkg.sv =====
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types and constants for the bypass crossfade with dry delay block.
// ----------------------------------------------------------------------------
package bcf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int LINE_DEPTH  = 4096;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);

    // Q16 mix, 0 = all dry, MIX_ONE = all wet
    localparam int MIX_FRAC = 16;
    localparam int MIX_BITS = MIX_FRAC + 1;
    localparam logic [MIX_BITS-1:0] MIX_ONE = MIX_BITS'(1 << MIX_FRAC);

    // (wet - dry) is one bit wider than a sample, mix gets a zero sign bit
    localparam int PROD_W = SAMPLE_BITS + 1 + MIX_BITS + 1;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (MIX_FRAC - 1));

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 1'b1;

    localparam logic [CFG_W-1:0] RAMP_STEP_RESET = 12'd64;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_DRY     = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [MIX_BITS-1:0]           mix_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [CFG_W-1:0]              cfg_t;

endpackage

// ===== rtl/bypass_crossfade_with_dry_delay_top.sv =====
// ----------------------------------------------------------------------------
// bypass_crossfade_with_dry_delay_top
// Delays the dry input through a ring memory to match the effect latency and
// crossfades linearly between wet and delayed dry under a Q16 mix ramp.
// Pipeline: ring read, multiply and sum registers, in that order, from the accepting
// edge to out_valid.
// Throughput: one stereo item per cycle while out_ready does not stall the output;
// one ring read and one write per item on the single ring RAM.
// Reset: clears write pointer, mix, priming count, target and pipeline valids.
// Ring entries not yet written read as zero, tracked by a wrap flag (no sweep).
// ----------------------------------------------------------------------------
module bypass_crossfade_with_dry_delay_top
    import bcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  sample_t              wet_left,
    input  sample_t              wet_right,
    input  sample_t              dry_left,
    input  sample_t              dry_right,
    input  logic                 bypass,
    input  logic                 block_start,
    input  logic [1:0]           mode,

    output logic                 out_valid,
    input  logic                 out_ready,
    output sample_t              out_left,
    output sample_t              out_right,
    output logic                 settled,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // configuration
    cfg_t delay_length_reg;
    cfg_t ramp_step_reg;

    // control state
    addr_t write_pos_reg;
    addr_t write_pos_next;
    logic  wrapped_reg;
    mix_t  wet_mix_reg;
    mix_t  wet_mix_next;
    cfg_t  prime_count_reg;
    cfg_t  prime_count_next;
    logic  mix_target_reg;
    logic  mix_target_next;
    logic  settled_next;

    logic  accept;
    addr_t delay_eff;
    addr_t rd_addr;
    logic  ring_hit;
    mix_t  step_ext;

    // stage 1: ring data returns
    logic    s1_valid_reg;
    sample_t s1_wet_l_reg;
    sample_t s1_wet_r_reg;
    sample_t s1_dry_l_reg;
    sample_t s1_dry_r_reg;
    logic    s1_hit_reg;
    logic    s1_nodelay_reg;
    mix_t    s1_mix_reg;
    logic    s1_settled_reg;

    logic [2*SAMPLE_BITS-1:0] ring_rdata;
    sample_t                  s1_dd_l;
    sample_t                  s1_dd_r;
    logic signed [SAMPLE_BITS:0] s1_diff_l;
    logic signed [SAMPLE_BITS:0] s1_diff_r;
    logic signed [PROD_W-1:0]    s1_prod_l;
    logic signed [PROD_W-1:0]    s1_prod_r;

    // stage 2: products
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_prod_l_reg;
    logic signed [PROD_W-1:0] s2_prod_r_reg;
    sample_t                  s2_dd_l_reg;
    sample_t                  s2_dd_r_reg;
    logic                     s2_settled_reg;

    logic signed [PROD_W-1:0] s2_rnd_l;
    logic signed [PROD_W-1:0] s2_rnd_r;

    // output register
    logic    out_valid_reg;
    sample_t out_left_reg;
    sample_t out_right_reg;
    logic    settled_reg;

    logic out_free;
    logic s2_free;
    logic s1_free;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;
    assign accept   = in_valid && s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg <= '0;
            ramp_step_reg    <= RAMP_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELAY_LENGTH: delay_length_reg <= cfg_data;
                REG_RAMP_STEP:    ramp_step_reg    <= cfg_data;
                default:          ramp_step_reg    <= ramp_step_reg;
            endcase
        end
    end

    // ring addressing
    always_comb
    begin
        if (32'(delay_length_reg) > LINE_DEPTH - 1)
            delay_eff = ADDR_W'(LINE_DEPTH - 1);
        else
            delay_eff = ADDR_W'(delay_length_reg);

        if (write_pos_reg >= delay_eff)
            rd_addr = write_pos_reg - delay_eff;
        else
            rd_addr = ADDR_W'({1'b0, write_pos_reg} + (ADDR_W + 1)'(LINE_DEPTH)
                              - {1'b0, delay_eff});

        if (32'(write_pos_reg) == LINE_DEPTH - 1)
            write_pos_next = '0;
        else
            write_pos_next = write_pos_reg + 1'b1;

        // before the first wrap only entries below the write pointer hold data
        ring_hit = (delay_eff != '0) && (wrapped_reg || (rd_addr < write_pos_reg));
    end

    // mix ramp, priming and target
    always_comb
    begin
        step_ext         = (ramp_step_reg == '0) ? mix_t'(1) : mix_t'(ramp_step_reg);
        prime_count_next = prime_count_reg;
        wet_mix_next     = wet_mix_reg;
        mix_target_next  = mix_target_reg;

        if (mode == MODE_RESTART && block_start)
        begin
            prime_count_next = delay_length_reg;
            wet_mix_next     = '0;
        end
        if (block_start)
            mix_target_next = !(bypass || (prime_count_next != '0));

        if (mode == MODE_DRY)
        begin
            wet_mix_next = '0;
        end
        else
        begin
            if (prime_count_next != '0)
                prime_count_next = prime_count_next - 1'b1;
            if (mix_target_next)
            begin
                if (MIX_ONE - wet_mix_next > step_ext)
                    wet_mix_next = wet_mix_next + step_ext;
                else
                    wet_mix_next = MIX_ONE;
            end
            else
            begin
                if (wet_mix_next > step_ext)
                    wet_mix_next = wet_mix_next - step_ext;
                else
                    wet_mix_next = '0;
            end
        end

        settled_next = mix_target_next ? (wet_mix_next == MIX_ONE) : (wet_mix_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg   <= '0;
            wrapped_reg     <= 1'b0;
            wet_mix_reg     <= '0;
            prime_count_reg <= '0;
            mix_target_reg  <= 1'b0;
        end
        else if (accept)
        begin
            write_pos_reg   <= write_pos_next;
            if (write_pos_next == '0)
                wrapped_reg <= 1'b1;
            wet_mix_reg     <= wet_mix_next;
            prime_count_reg <= prime_count_next;
            mix_target_reg  <= mix_target_next;
        end
    end

    // read and write hit the same entry only at zero delay, where the ring data is not used
    bcf_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (write_pos_reg),
        .wdata ({dry_left, dry_right}),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ring_rdata)
    );

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= accept;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_wet_l_reg   <= wet_left;
            s1_wet_r_reg   <= wet_right;
            s1_dry_l_reg   <= dry_left;
            s1_dry_r_reg   <= dry_right;
            s1_hit_reg     <= ring_hit;
            s1_nodelay_reg <= (delay_eff == '0);
            s1_mix_reg     <= wet_mix_next;
            s1_settled_reg <= settled_next;
        end
    end

    // delayed dry: ring data, the input itself at zero delay, else an unwritten zero
    // out = dd + (wet - dd) * mix, rounded half up
    always_comb
    begin
        if (s1_hit_reg)
        begin
            s1_dd_l = sample_t'(ring_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            s1_dd_r = sample_t'(ring_rdata[SAMPLE_BITS-1:0]);
        end
        else if (s1_nodelay_reg)
        begin
            s1_dd_l = s1_dry_l_reg;
            s1_dd_r = s1_dry_r_reg;
        end
        else
        begin
            s1_dd_l = '0;
            s1_dd_r = '0;
        end
        s1_diff_l = {s1_wet_l_reg[SAMPLE_BITS-1], s1_wet_l_reg}
                    - {s1_dd_l[SAMPLE_BITS-1], s1_dd_l};
        s1_diff_r = {s1_wet_r_reg[SAMPLE_BITS-1], s1_wet_r_reg}
                    - {s1_dd_r[SAMPLE_BITS-1], s1_dd_r};
        s1_prod_l = PROD_W'(s1_diff_l) * PROD_W'($signed({1'b0, s1_mix_reg}));
        s1_prod_r = PROD_W'(s1_diff_r) * PROD_W'($signed({1'b0, s1_mix_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_prod_l_reg  <= s1_prod_l;
            s2_prod_r_reg  <= s1_prod_r;
            s2_dd_l_reg    <= s1_dd_l;
            s2_dd_r_reg    <= s1_dd_r;
            s2_settled_reg <= s1_settled_reg;
        end
    end

    assign s2_rnd_l = (s2_prod_l_reg + ROUND_HALF) >>> MIX_FRAC;
    assign s2_rnd_r = (s2_prod_r_reg + ROUND_HALF) >>> MIX_FRAC;

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg)
        begin
            out_left_reg  <= s2_dd_l_reg + sample_t'(s2_rnd_l[SAMPLE_BITS-1:0]);
            out_right_reg <= s2_dd_r_reg + sample_t'(s2_rnd_r[SAMPLE_BITS-1:0]);
            settled_reg   <= s2_settled_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;
    assign settled   = settled_reg;

endmodule

// ===== rtl/bcf_ram.sv =====
// ----------------------------------------------------------------------------
// bcf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bcf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bcf_checker.sv =====
// ----------------------------------------------------------------------------
// bcf_checker
// Port-level checks on the crossfade block: item bookkeeping and stalls.
// ----------------------------------------------------------------------------
module bcf_checker
    import bcf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t out_left,
    input sample_t out_right,
    input logic    settled
);

    // items accepted but not yet delivered
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_valid && in_ready)
            inflight_next = inflight_next + 1'b1;
        if (out_valid && out_ready)
            inflight_next = inflight_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_left)
                                    && $stable(out_right) && $stable(settled))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result without an accepted item");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd3)
        else $error("more items in flight than pipeline stages");

    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && inflight_reg == 3'd3)
        else $error("input stalled while pipeline has room");

endmodule

bind bypass_crossfade_with_dry_delay_top bcf_checker u_bcf_checker (.*);
